@@ rtl/vp2r_pkg.sv @@
// ----------------------------------------------------------------------------
// vp2r_pkg
// Shared types and codes for the pixel to rgb888 converter.
// ----------------------------------------------------------------------------
package vp2r_pkg;

    // input commands
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    // visual classes
    localparam logic [1:0] CLASS_INDEXED = 2'd0;
    localparam logic [1:0] CLASS_TRUE    = 2'd1;
    localparam logic [1:0] CLASS_DIRECT  = 2'd2;
    localparam logic [1:0] CLASS_UNUSED  = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VISUAL_CLASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_POS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_POS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_POS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 3'd7;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [1:0] visual_class;
        logic [4:0] red_pos;
        logic [4:0] red_width;
        logic [4:0] green_pos;
        logic [4:0] green_width;
        logic [4:0] blue_pos;
        logic [4:0] blue_width;
        logic       alpha_enable;
    } cfg_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic        cmd;
        logic        err;     // out of range index, or ignored write
        logic [7:0]  addr_r;  // colormap address or aligned top byte
        logic [7:0]  addr_g;
        logic [7:0]  addr_b;
        logic [23:0] data;    // entry bytes for a write
    } item_t;

endpackage

@@ rtl/visual_pixel_to_rgb888_core.sv @@
// ----------------------------------------------------------------------------
// visual_pixel_to_rgb888_core
// Raw display pixel to 8-bit red, green, blue and alpha, three visual classes.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_tready is high and gives one result per
// convert item at one per clock while m_tready is high; a colormap write item
// gives no result. A convert result passes the two-entry queue, the registered
// colormap read and the output register, in that order. Throughput is set by
// the single colormap access per item, made on three byte-wide lanes. The
// colormap reads as all zero right after reset through per-entry valid bits,
// so no clearing pass is needed. The user must write configuration through the
// cfg port only while no item is in flight; the block does not enforce this.
module visual_pixel_to_rgb888_core #(
    parameter int unsigned COLORMAP_SIZE = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vp2r_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vp2r_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_word, entry_index, entry_red, entry_green, entry_blue
    input  logic [63:0]                        s_tdata,
    // command
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]                        m_tdata,
    // index_error
    output logic                               m_tuser
);

    vp2r_pkg::cfg_t  cfg_reg;
    vp2r_pkg::item_t front_item;
    vp2r_pkg::item_t queue_item;
    logic            queue_valid;
    logic            queue_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.visual_class <= vp2r_pkg::CLASS_TRUE;
            cfg_reg.red_pos      <= 5'd16;
            cfg_reg.red_width    <= 5'd8;
            cfg_reg.green_pos    <= 5'd8;
            cfg_reg.green_width  <= 5'd8;
            cfg_reg.blue_pos     <= 5'd0;
            cfg_reg.blue_width   <= 5'd8;
            cfg_reg.alpha_enable <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vp2r_pkg::REG_VISUAL_CLASS: cfg_reg.visual_class <= cfg_data[1:0];
                vp2r_pkg::REG_RED_POS:      cfg_reg.red_pos      <= cfg_data;
                vp2r_pkg::REG_RED_WIDTH:    cfg_reg.red_width    <= cfg_data;
                vp2r_pkg::REG_GREEN_POS:    cfg_reg.green_pos    <= cfg_data;
                vp2r_pkg::REG_GREEN_WIDTH:  cfg_reg.green_width  <= cfg_data;
                vp2r_pkg::REG_BLUE_POS:     cfg_reg.blue_pos     <= cfg_data;
                vp2r_pkg::REG_BLUE_WIDTH:   cfg_reg.blue_width   <= cfg_data;
                vp2r_pkg::REG_ALPHA_ENABLE: cfg_reg.alpha_enable <= cfg_data[0];
                default:                    cfg_reg.alpha_enable <= cfg_reg.alpha_enable;
            endcase
        end
    end

    vp2r_front #(
        .COLORMAP_SIZE (COLORMAP_SIZE)
    ) u_front (
        .cfg            (cfg_reg),
        .in_cmd         (s_tuser),
        .in_pixel_word  (s_tdata[31:0]),
        .in_entry_index (s_tdata[39:32]),
        .in_entry_rgb   ({s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]}),
        .out_item       (front_item)
    );

    vp2r_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    vp2r_back #(
        .COLORMAP_SIZE (COLORMAP_SIZE)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (queue_valid),
        .in_ready        (queue_ready),
        .in_item         (queue_item),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_red         (m_tdata[7:0]),
        .out_green       (m_tdata[15:8]),
        .out_blue        (m_tdata[23:16]),
        .out_alpha       (m_tdata[31:24]),
        .out_index_error (m_tuser)
    );

endmodule

@@ rtl/vp2r_front.sv @@
// ----------------------------------------------------------------------------
// vp2r_front
// Classifies an incoming item: field alignment, colormap addresses, range check.
// ----------------------------------------------------------------------------
module vp2r_front #(
    parameter int unsigned COLORMAP_SIZE = 256
) (
    input  vp2r_pkg::cfg_t  cfg,
    input  logic            in_cmd,
    input  logic [31:0]     in_pixel_word,
    input  logic [7:0]      in_entry_index,
    input  logic [23:0]     in_entry_rgb,
    output vp2r_pkg::item_t out_item
);

    // top byte of the field once aligned so its msb sits at bit 31
    function automatic logic [7:0] top_byte(input logic [31:0] pix,
                                            input logic [4:0]  sh,
                                            input logic [4:0]  pr);
        logic [31:0] mask;
        logic [31:0] field;
        logic [39:0] wide;
        mask  = ~(32'hffff_ffff << pr);
        field = (pix >> sh) & mask;
        wide  = {field, 8'h00} >> pr;
        return wide[7:0];
    endfunction

    logic [7:0] top_r;
    logic [7:0] top_g;
    logic [7:0] top_b;
    logic       pix_ok;
    logic       tops_ok;
    logic       entry_ok;

    always_comb begin
        top_r    = top_byte(in_pixel_word, cfg.red_pos, cfg.red_width);
        top_g    = top_byte(in_pixel_word, cfg.green_pos, cfg.green_width);
        top_b    = top_byte(in_pixel_word, cfg.blue_pos, cfg.blue_width);
        pix_ok   = in_pixel_word < 32'(COLORMAP_SIZE);
        tops_ok  = ({1'b0, top_r} < 9'(COLORMAP_SIZE)) &&
                   ({1'b0, top_g} < 9'(COLORMAP_SIZE)) &&
                   ({1'b0, top_b} < 9'(COLORMAP_SIZE));
        entry_ok = {1'b0, in_entry_index} < 9'(COLORMAP_SIZE);

        out_item.cmd    = in_cmd;
        out_item.data   = in_entry_rgb;
        out_item.err    = 1'b0;
        out_item.addr_r = top_r;
        out_item.addr_g = top_g;
        out_item.addr_b = top_b;

        if (in_cmd == vp2r_pkg::CMD_WRITE) begin
            out_item.addr_r = in_entry_index;
            out_item.err    = !entry_ok;
        end else begin
            unique case (cfg.visual_class)
                vp2r_pkg::CLASS_INDEXED: begin
                    out_item.addr_r = in_pixel_word[7:0];
                    out_item.addr_g = in_pixel_word[7:0];
                    out_item.addr_b = in_pixel_word[7:0];
                    out_item.err    = !pix_ok;
                end
                vp2r_pkg::CLASS_DIRECT: out_item.err = !tops_ok;
                vp2r_pkg::CLASS_TRUE:   out_item.err = 1'b0;
                vp2r_pkg::CLASS_UNUSED: out_item.err = 1'b0;
                default:                out_item.err = 1'b0;
            endcase
        end
    end

endmodule

@@ rtl/vp2r_queue.sv @@
// ----------------------------------------------------------------------------
// vp2r_queue
// Two-entry queue between the classifying front and the colormap back end.
// ----------------------------------------------------------------------------
module vp2r_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  vp2r_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output vp2r_pkg::item_t out_item
);

    vp2r_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/vp2r_back.sv @@
// ----------------------------------------------------------------------------
// vp2r_back
// Colormap storage, lookup and true-colour fill, with the result register.
// ----------------------------------------------------------------------------
module vp2r_back #(
    parameter int unsigned COLORMAP_SIZE = 256
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  vp2r_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  vp2r_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic [7:0]      out_alpha,
    output logic            out_index_error
);

    localparam int unsigned AW = $clog2(COLORMAP_SIZE);

    // repeat the field every prec bits down from the top byte
    function automatic logic [7:0] fill_byte(input logic [7:0] top,
                                             input logic [4:0] pr);
        logic [7:0] comp;
        logic [7:0] step_pos;
        comp = 8'h00;
        for (int k = 0; k < 8; k++) begin
            step_pos = 8'(k) * {3'b000, pr};
            if (step_pos < 8'd8) begin
                comp = comp | (top >> step_pos[2:0]);
            end
        end
        return comp;
    endfunction

    // one byte lane per channel so direct mode reads three addresses at once
    logic [7:0]               map_r [COLORMAP_SIZE];
    logic [7:0]               map_g [COLORMAP_SIZE];
    logic [7:0]               map_b [COLORMAP_SIZE];
    logic [COLORMAP_SIZE-1:0] map_vld_reg;

    logic            b1_valid_reg;
    vp2r_pkg::item_t b1_item_reg;
    logic [7:0]      rd_r_reg;
    logic [7:0]      rd_g_reg;
    logic [7:0]      rd_b_reg;
    logic [2:0]      rd_vld_reg;

    logic            out_valid_reg;
    logic [7:0]      red_reg,   red_next;
    logic [7:0]      green_reg, green_next;
    logic [7:0]      blue_reg,  blue_next;
    logic [7:0]      alpha_reg, alpha_next;
    logic            err_reg,   err_next;

    logic b1_is_conv;
    logic out_load;
    logic b1_load;
    logic map_wr;
    logic [7:0] lut_r;
    logic [7:0] lut_g;
    logic [7:0] lut_b;

    assign b1_is_conv = (b1_item_reg.cmd == vp2r_pkg::CMD_CONVERT);
    assign out_load   = b1_valid_reg && b1_is_conv && (!out_valid_reg || out_ready);
    assign b1_load    = in_valid && (!b1_valid_reg || !b1_is_conv || out_load);
    assign in_ready   = !b1_valid_reg || !b1_is_conv || out_load;
    assign map_wr     = b1_load && (in_item.cmd == vp2r_pkg::CMD_WRITE) && !in_item.err;

    // colormap write and registered read
    always_ff @(posedge aclk) begin
        if (map_wr) begin
            map_r[in_item.addr_r[AW-1:0]] <= in_item.data[23:16];
            map_g[in_item.addr_r[AW-1:0]] <= in_item.data[15:8];
            map_b[in_item.addr_r[AW-1:0]] <= in_item.data[7:0];
        end
        if (b1_load) begin
            b1_item_reg <= in_item;
            rd_r_reg    <= map_r[in_item.addr_r[AW-1:0]];
            rd_g_reg    <= map_g[in_item.addr_g[AW-1:0]];
            rd_b_reg    <= map_b[in_item.addr_b[AW-1:0]];
            rd_vld_reg  <= {map_vld_reg[in_item.addr_b[AW-1:0]],
                            map_vld_reg[in_item.addr_g[AW-1:0]],
                            map_vld_reg[in_item.addr_r[AW-1:0]]};
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg <= '0;
        end else if (map_wr) begin
            map_vld_reg[in_item.addr_r[AW-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        lut_r = rd_vld_reg[0] ? rd_r_reg : 8'h00;
        lut_g = rd_vld_reg[1] ? rd_g_reg : 8'h00;
        lut_b = rd_vld_reg[2] ? rd_b_reg : 8'h00;

        red_next   = 8'h00;
        green_next = 8'h00;
        blue_next  = 8'h00;
        err_next   = b1_item_reg.err;
        alpha_next = cfg.alpha_enable ? vp2r_pkg::ALPHA_OPAQUE : 8'h00;

        unique case (cfg.visual_class)
            vp2r_pkg::CLASS_INDEXED, vp2r_pkg::CLASS_DIRECT: begin
                if (!b1_item_reg.err) begin
                    red_next   = lut_r;
                    green_next = lut_g;
                    blue_next  = lut_b;
                end
            end
            vp2r_pkg::CLASS_TRUE: begin
                red_next   = fill_byte(b1_item_reg.addr_r, cfg.red_width);
                green_next = fill_byte(b1_item_reg.addr_g, cfg.green_width);
                blue_next  = fill_byte(b1_item_reg.addr_b, cfg.blue_width);
                err_next   = 1'b0;
            end
            vp2r_pkg::CLASS_UNUSED: err_next = 1'b0;
            default:                err_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (b1_load) begin
                b1_valid_reg <= 1'b1;
            end else if (!b1_is_conv || out_load) begin
                b1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_red         = red_reg;
    assign out_green       = green_reg;
    assign out_blue        = blue_reg;
    assign out_alpha       = alpha_reg;
    assign out_index_error = err_reg;

endmodule

@@ tb/visual_pixel_to_rgb888_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// visual_pixel_to_rgb888_core_tb
// Self-checking bench for the pixel to rgb888 converter. A short directed
// table walks reset defaults, colormap loads, every visual class, errors and
// the odd field cases. Random phases follow, each with a fresh register set,
// under random stalls on both streams. Every result is checked against a table
// expectation or a local prediction of the conversion and colormap contents.
// ----------------------------------------------------------------------------
module visual_pixel_to_rgb888_core_tb;

    localparam int COLORMAP_SIZE = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDX_W         = vp2r_pkg::CFG_IDX_W;
    localparam int DATA_W        = vp2r_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       index_err;
    } rgb_result_t;

    localparam rgb_result_t NO_RGB = '0;

    typedef enum logic [1:0] {ROW_REG, ROW_CONVERT, ROW_LOAD} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [IDX_W-1:0]  reg_idx;
        logic [DATA_W-1:0] reg_val;
        logic [31:0]       pixel;
        logic [7:0]        entry_idx;
        logic [7:0]        entry_r;
        logic [7:0]        entry_g;
        logic [7:0]        entry_b;
        bit                typed;
        rgb_result_t       want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [DATA_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // pixel_word, entry_index, entry_red, entry_green, entry_blue
    logic [63:0]           s_tdata;
    // command
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha
    logic [31:0]           m_tdata;
    // index_error
    logic                  m_tuser;

    vp2r_pkg::cfg_t disp_cfg;
    logic [23:0]    cmap_model [COLORMAP_SIZE];
    rgb_result_t    pending_rgb [$];
    logic [7:0]     loaded_idx [$];
    dir_row_t       dir_rows [$];
    int             mismatch_count = 0;
    int             stall_left = 0;
    int             cycle_count = 0;
    bit             src_steady = 1'b0;
    bit             sink_steady = 1'b0;

    visual_pixel_to_rgb888_core #(
        .COLORMAP_SIZE(COLORMAP_SIZE)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // field cut out of the pixel, top bit moved to bit 31
    function automatic logic [31:0] align_to_top(logic [31:0] pix, logic [4:0] shift,
                                                 logic [4:0] prec);
        logic [63:0] fld;
        if (prec == 5'd0) return 32'd0;
        fld = ({32'd0, pix} >> shift) & ((64'd1 << prec) - 64'd1);
        fld = fld << (32 - int'(prec));
        return fld[31:0];
    endfunction

    // top byte filled by repeating the field every prec bits
    function automatic logic [7:0] true_byte(logic [31:0] pix, logic [4:0] shift,
                                             logic [4:0] prec);
        logic [31:0] aligned;
        logic [7:0]  acc;
        acc = 8'd0;
        if (prec == 5'd0) return acc;
        aligned = align_to_top(pix, shift, prec);
        for (int pos = 24; pos < 32; pos += int'(prec))
            acc |= 8'(aligned >> pos);
        return acc;
    endfunction

    function automatic rgb_result_t predict_rgb(logic [31:0] pix);
        rgb_result_t res;
        logic [7:0]  ri, gi, bi;
        res = NO_RGB;
        res.alpha = disp_cfg.alpha_enable ? vp2r_pkg::ALPHA_OPAQUE : 8'd0;
        case (disp_cfg.visual_class)
            vp2r_pkg::CLASS_INDEXED: begin
                if (pix < COLORMAP_SIZE)
                    {res.red, res.green, res.blue} = cmap_model[pix[7:0]];
                else
                    res.index_err = 1'b1;
            end
            vp2r_pkg::CLASS_TRUE: begin
                res.red   = true_byte(pix, disp_cfg.red_pos, disp_cfg.red_width);
                res.green = true_byte(pix, disp_cfg.green_pos, disp_cfg.green_width);
                res.blue  = true_byte(pix, disp_cfg.blue_pos, disp_cfg.blue_width);
            end
            vp2r_pkg::CLASS_DIRECT: begin
                ri = 8'(align_to_top(pix, disp_cfg.red_pos, disp_cfg.red_width) >> 24);
                gi = 8'(align_to_top(pix, disp_cfg.green_pos, disp_cfg.green_width) >> 24);
                bi = 8'(align_to_top(pix, disp_cfg.blue_pos, disp_cfg.blue_width) >> 24);
                if (ri < COLORMAP_SIZE && gi < COLORMAP_SIZE && bi < COLORMAP_SIZE) begin
                    res.red   = cmap_model[ri][23:16];
                    res.green = cmap_model[gi][15:8];
                    res.blue  = cmap_model[bi][7:0];
                end else begin
                    res.index_err = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        case (idx)
            vp2r_pkg::REG_VISUAL_CLASS: disp_cfg.visual_class = val[1:0];
            vp2r_pkg::REG_RED_POS:      disp_cfg.red_pos      = val;
            vp2r_pkg::REG_RED_WIDTH:    disp_cfg.red_width    = val;
            vp2r_pkg::REG_GREEN_POS:    disp_cfg.green_pos    = val;
            vp2r_pkg::REG_GREEN_WIDTH:  disp_cfg.green_width  = val;
            vp2r_pkg::REG_BLUE_POS:     disp_cfg.blue_pos     = val;
            vp2r_pkg::REG_BLUE_WIDTH:   disp_cfg.blue_width   = val;
            vp2r_pkg::REG_ALPHA_ENABLE: disp_cfg.alpha_enable = val[0];
            default: ;
        endcase
    endfunction

    function automatic dir_row_t reg_row(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        dir_row_t row;
        row = '{kind: ROW_REG, want: NO_RGB, default: '0};
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t convert_row(logic [31:0] pix, bit typed, rgb_result_t want);
        dir_row_t row;
        row = '{kind: ROW_CONVERT, want: NO_RGB, default: '0};
        row.pixel = pix;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t load_row(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
        dir_row_t row;
        row = '{kind: ROW_LOAD, want: NO_RGB, default: '0};
        row.entry_idx = idx;
        row.entry_r   = r;
        row.entry_g   = g;
        row.entry_b   = b;
        return row;
    endfunction

    function automatic logic [4:0] pick_prec();
        int r;
        r = $urandom_range(0, 9);
        if (r == 7) return 5'd0;
        if (r == 8) return 5'd16;
        if (r == 9) return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    function automatic logic [4:0] pick_shift();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 5'd0;
        if (r == 1) return 5'd31;
        return 5'($urandom_range(0, 31));
    endfunction

    // one item on the input stream; valid stays up when the next item follows at once
    task automatic push_item(logic cmd, logic [63:0] data);
        int gap;
        cfg_valid <= 1'b0;
        gap = src_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_convert(logic [31:0] pix, bit typed, rgb_result_t want);
        push_item(vp2r_pkg::CMD_CONVERT, {32'($urandom), pix});
        pending_rgb.push_back(typed ? want : predict_rgb(pix));
    endtask

    task automatic send_load(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        push_item(vp2r_pkg::CMD_WRITE, {b, g, r, idx, 32'($urandom)});
        if (idx < COLORMAP_SIZE) begin
            cmap_model[idx] = {r, g, b};
            loaded_idx.push_back(idx);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    // wait out every result, then the trailing writes that give none
    task automatic quiesce();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_rgb.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %08h/%0b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    check_field("red", pending_rgb[0].red, m_tdata[7:0]);
                    check_field("green", pending_rgb[0].green, m_tdata[15:8]);
                    check_field("blue", pending_rgb[0].blue, m_tdata[23:16]);
                    check_field("alpha", pending_rgb[0].alpha, m_tdata[31:24]);
                    check_field("index_error", {7'd0, pending_rgb[0].index_err},
                                {7'd0, m_tuser});
                    void'(pending_rgb.pop_front());
                end
                stall_left = sink_steady ? 0 : $urandom_range(0, 9);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("visual_pixel_to_rgb888_core_tb NOT OK");
        $finish;
    end

    initial begin
        logic [31:0] pix;
        int          pick;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = vp2r_pkg::CMD_CONVERT;

        disp_cfg = '{visual_class: vp2r_pkg::CLASS_TRUE, red_pos: 5'd16, red_width: 5'd8,
                     green_pos: 5'd8, green_width: 5'd8, blue_pos: 5'd0,
                     blue_width: 5'd8, alpha_enable: 1'b0};
        foreach (cmap_model[k]) cmap_model[k] = 24'd0;

        // reset defaults, then loads and every class
        dir_rows.push_back(convert_row(32'h0000_0000, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}));
        dir_rows.push_back(convert_row(32'hffff_ffff, 1'b1, '{8'hff, 8'hff, 8'hff, 8'h00, 1'b0}));
        dir_rows.push_back(convert_row(32'h0012_3456, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h00, 1'b0}));
        dir_rows.push_back(load_row(8'd0, 8'h11, 8'h22, 8'h33));
        dir_rows.push_back(load_row(8'd255, 8'hff, 8'hfe, 8'hfd));
        dir_rows.push_back(load_row(8'd1, 8'h80, 8'h40, 8'h20));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_INDEXED)));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_ALPHA_ENABLE, 5'd1));
        dir_rows.push_back(convert_row(32'd0, 1'b1, '{8'h11, 8'h22, 8'h33, 8'hff, 1'b0}));
        dir_rows.push_back(convert_row(32'd255, 1'b1, '{8'hff, 8'hfe, 8'hfd, 8'hff, 1'b0}));
        // never loaded entry reads as zero
        dir_rows.push_back(convert_row(32'd2, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hff, 1'b0}));
        dir_rows.push_back(convert_row(32'd256, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hff, 1'b1}));
        dir_rows.push_back(convert_row(32'hffff_ffff, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hff, 1'b1}));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_DIRECT)));
        dir_rows.push_back(convert_row(32'hffff_ffff, 1'b1, '{8'hff, 8'hfe, 8'hfd, 8'hff, 1'b0}));
        dir_rows.push_back(convert_row(32'h0000_0100, 1'b0, NO_RGB));
        // empty red field
        dir_rows.push_back(reg_row(vp2r_pkg::REG_RED_WIDTH, 5'd0));
        dir_rows.push_back(convert_row(32'h00ff_0001, 1'b0, NO_RGB));
        // green field runs past bit 31
        dir_rows.push_back(reg_row(vp2r_pkg::REG_GREEN_POS, 5'd28));
        dir_rows.push_back(convert_row(32'hf000_0f00, 1'b0, NO_RGB));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_TRUE)));
        dir_rows.push_back(convert_row(32'hf0a5_c3ff, 1'b0, NO_RGB));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_BLUE_WIDTH, 5'd3));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_BLUE_POS, 5'd5));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_RED_POS, 5'd31));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_RED_WIDTH, 5'd16));
        dir_rows.push_back(convert_row(32'h8000_00a5, 1'b0, NO_RGB));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_UNUSED)));
        dir_rows.push_back(convert_row(32'hffff_ffff, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hff, 1'b0}));
        dir_rows.push_back(reg_row(vp2r_pkg::REG_ALPHA_ENABLE, 5'd0));
        dir_rows.push_back(convert_row(32'h1234_5678, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_REG: begin
                    quiesce();
                    write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                end
                ROW_CONVERT: send_convert(dir_rows[i].pixel, dir_rows[i].typed,
                                          dir_rows[i].want);
                default: send_load(dir_rows[i].entry_idx, dir_rows[i].entry_r,
                                   dir_rows[i].entry_g, dir_rows[i].entry_b);
            endcase
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiesce();
            if (phase == 0) begin
                // narrowest fields at the bottom of the word
                write_reg(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_TRUE));
                write_reg(vp2r_pkg::REG_RED_POS, 5'd0);
                write_reg(vp2r_pkg::REG_RED_WIDTH, 5'd1);
                write_reg(vp2r_pkg::REG_GREEN_POS, 5'd0);
                write_reg(vp2r_pkg::REG_GREEN_WIDTH, 5'd1);
                write_reg(vp2r_pkg::REG_BLUE_POS, 5'd0);
                write_reg(vp2r_pkg::REG_BLUE_WIDTH, 5'd1);
                write_reg(vp2r_pkg::REG_ALPHA_ENABLE, 5'd0);
            end else if (phase == 1) begin
                // widest fields at the top of the word
                write_reg(vp2r_pkg::REG_VISUAL_CLASS, DATA_W'(vp2r_pkg::CLASS_DIRECT));
                write_reg(vp2r_pkg::REG_RED_POS, 5'd31);
                write_reg(vp2r_pkg::REG_RED_WIDTH, 5'd31);
                write_reg(vp2r_pkg::REG_GREEN_POS, 5'd31);
                write_reg(vp2r_pkg::REG_GREEN_WIDTH, 5'd31);
                write_reg(vp2r_pkg::REG_BLUE_POS, 5'd31);
                write_reg(vp2r_pkg::REG_BLUE_WIDTH, 5'd31);
                write_reg(vp2r_pkg::REG_ALPHA_ENABLE, 5'd31);
            end else begin
                pick = $urandom_range(0, 9);
                // upper data bits of the class register are don't care
                write_reg(vp2r_pkg::REG_VISUAL_CLASS, {3'($urandom),
                          (phase == 2) ? vp2r_pkg::CLASS_INDEXED :
                          (pick < 3) ? vp2r_pkg::CLASS_INDEXED :
                          (pick < 6) ? vp2r_pkg::CLASS_TRUE :
                          (pick < 9) ? vp2r_pkg::CLASS_DIRECT : vp2r_pkg::CLASS_UNUSED});
                write_reg(vp2r_pkg::REG_RED_POS, pick_shift());
                write_reg(vp2r_pkg::REG_RED_WIDTH, pick_prec());
                write_reg(vp2r_pkg::REG_GREEN_POS, pick_shift());
                write_reg(vp2r_pkg::REG_GREEN_WIDTH, pick_prec());
                write_reg(vp2r_pkg::REG_BLUE_POS, pick_shift());
                write_reg(vp2r_pkg::REG_BLUE_WIDTH, pick_prec());
                write_reg(vp2r_pkg::REG_ALPHA_ENABLE, 5'($urandom));
            end
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    send_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    pick = $urandom_range(0, 9);
                    if (disp_cfg.visual_class == vp2r_pkg::CLASS_INDEXED) begin
                        if (pick < 5 && loaded_idx.size() != 0)
                            pix = {24'd0, loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]};
                        else if (pick < 8)
                            pix = $urandom_range(0, COLORMAP_SIZE - 1);
                        else if (pick == 8)
                            pix = $urandom_range(0, 1) ? 32'd256 : 32'hffff_ffff;
                        else
                            pix = $urandom;
                    end else begin
                        if (pick == 0)
                            pix = 32'd0;
                        else if (pick == 1)
                            pix = 32'hffff_ffff;
                        else
                            pix = $urandom;
                    end
                    send_convert(pix, 1'b0, NO_RGB);
                end
            end
        end

        quiesce();
        if (mismatch_count == 0)
            $display("visual_pixel_to_rgb888_core_tb OK");
        else
            $display("visual_pixel_to_rgb888_core_tb NOT OK");
        $finish;
    end

endmodule
